@@ src/cht_pkg.sv @@
// Shared widths, operation and status codes, and the operation type of the hash table.
package cht_pkg;

    localparam int MODE_W   = 2;
    localparam int KEY_W    = 31;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;
    localparam int CFG_W    = 7;

    // Key bits folded into the remainder per front cycle.
    localparam int DIGITS_PER_CYCLE = 4;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GET    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

    localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = 7'd64;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } cht_op_t;

endpackage

@@ src/cht_if.sv @@
// Valid/ready channel interfaces for operation items and result items.
interface cht_in_if;
    import cht_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [MODE_W-1:0]       mode;
    logic [KEY_W-1:0]        lookup_key;
    logic signed [VAL_W-1:0] entry_value;

    modport source (output valid, mode, lookup_key, entry_value, input ready);
    modport sink   (input valid, mode, lookup_key, entry_value, output ready);
endinterface

interface cht_out_if;
    import cht_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic signed [VAL_W-1:0] found_value;
    logic [COUNT_W-1:0]      entry_count;

    modport source (output valid, status, found_value, entry_count, input ready);
    modport sink   (input valid, status, found_value, entry_count, output ready);
endinterface

@@ src/cht_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cht_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/cht_front.sv @@
// Front end: accepts operation items and computes the bucket as key modulo the bucket count.
module cht_front #(
    parameter int MAX_BUCKETS = 64,
    parameter int BUCKET_W    = 6
) (
    input  logic                      clk,
    input  logic                      rst_n,
    cht_in_if.sink                    in_ch,
    input  logic [cht_pkg::CFG_W-1:0] bucket_count,
    input  logic                      init_done,
    output logic                      push_valid,
    input  logic                      push_ready,
    output cht_pkg::cht_op_t          push_op,
    output logic [BUCKET_W-1:0]       push_bucket
);
    import cht_pkg::*;

    localparam int DIV_W = $clog2(MAX_BUCKETS + 1);
    localparam int STEPS = (KEY_W + DIGITS_PER_CYCLE - 1) / DIGITS_PER_CYCLE;
    localparam int PAD_W = STEPS * DIGITS_PER_CYCLE;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [PAD_W-1:0] shift_reg, shift_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] divisor_reg, divisor_next;
    cht_op_t          op_reg, op_next;

    logic [31:0]      bc_wide;
    logic [DIV_W-1:0] divisor_eff;
    logic [DIV_W-1:0] rem_step;
    logic [DIV_W:0]   trial;
    logic             accept;
    logic             computing;

    // A zero count acts as one bucket, a count above the maximum saturates.
    always_comb
    begin
        bc_wide = {{(32 - CFG_W){1'b0}}, bucket_count};
        if (bc_wide == 32'd0)
        begin
            bc_wide = 32'd1;
        end
        else if (bc_wide > 32'(MAX_BUCKETS))
        begin
            bc_wide = 32'(MAX_BUCKETS);
        end
        divisor_eff = bc_wide[DIV_W-1:0];
    end

    // Restoring remainder, most significant key bits first.
    always_comb
    begin
        rem_step = rem_reg;
        trial    = '0;
        for (int i = 0; i < DIGITS_PER_CYCLE; i++)
        begin
            trial = {rem_step, shift_reg[PAD_W-1-i]};
            if (trial >= {1'b0, divisor_reg})
            begin
                trial = trial - {1'b0, divisor_reg};
            end
            rem_step = trial[DIV_W-1:0];
        end
    end

    assign in_ch.ready = init_done && !busy_reg;
    assign accept      = in_ch.valid && in_ch.ready;
    assign computing   = busy_reg && (cnt_reg != CNT_W'(STEPS));
    assign push_valid  = busy_reg && (cnt_reg == CNT_W'(STEPS));
    assign push_op     = op_reg;
    assign push_bucket = BUCKET_W'(rem_reg);

    always_comb
    begin
        busy_next    = busy_reg;
        cnt_next     = cnt_reg;
        shift_next   = shift_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        op_next      = op_reg;
        if (accept)
        begin
            busy_next     = 1'b1;
            cnt_next      = '0;
            shift_next    = PAD_W'(in_ch.lookup_key);
            rem_next      = '0;
            divisor_next  = divisor_eff;
            op_next.mode  = in_ch.mode;
            op_next.key   = in_ch.lookup_key;
            op_next.value = in_ch.entry_value;
        end
        else if (computing)
        begin
            cnt_next   = cnt_reg + CNT_W'(1);
            shift_next = shift_reg << DIGITS_PER_CYCLE;
            rem_next   = rem_step;
        end
        else if (push_valid && push_ready)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg   <= shift_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        op_reg      <= op_next;
    end

endmodule

@@ src/cht_queue.sv @@
// Two-entry queue that decouples the front end from the back end.
module cht_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       fill_reg, fill_next;
    logic             do_push, do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ src/cht_back.sv @@
// Back end: walks bucket chains in the entry pool and produces one result item per operation.
module cht_back #(
    parameter int MAX_BUCKETS  = 64,
    parameter int POOL_ENTRIES = 256,
    parameter int BUCKET_W     = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  cht_pkg::cht_op_t    pop_op,
    input  logic [BUCKET_W-1:0] pop_bucket,
    output logic                init_done,
    cht_out_if.source           out_ch
);
    import cht_pkg::*;

    localparam int ENTRY_W = $clog2(POOL_ENTRIES);
    localparam int LINK_W  = ENTRY_W + 1;
    localparam int HELD_W  = $clog2(POOL_ENTRIES + 1);
    localparam int ENT_W   = KEY_W + VAL_W + LINK_W;
    localparam logic [LINK_W-1:0]   NIL_LINK    = LINK_W'(POOL_ENTRIES);
    localparam logic [HELD_W-1:0]   POOL_COUNT  = HELD_W'(POOL_ENTRIES);
    localparam logic [BUCKET_W-1:0] LAST_BUCKET = BUCKET_W'(MAX_BUCKETS - 1);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HEAD  = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_CLEAR = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [BUCKET_W-1:0] sweep_reg, sweep_next;
    logic [HELD_W-1:0]   top_reg, top_next;
    logic [HELD_W-1:0]   low_reg, low_next;
    logic [HELD_W-1:0]   held_reg, held_next;
    logic                out_valid_reg, out_valid_next;

    cht_op_t             op_reg, op_next;
    logic [BUCKET_W-1:0] bucket_reg, bucket_next;
    logic [ENTRY_W-1:0]  new_reg, new_next;
    logic [LINK_W-1:0]   cur_reg, cur_next;
    logic [LINK_W-1:0]   prev_reg, prev_next;
    logic [KEY_W+VAL_W-1:0] prev_word_reg, prev_word_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [VAL_W-1:0]    found_reg, found_next;
    logic [COUNT_W-1:0]  count_reg, count_next;

    logic                heads_we;
    logic [BUCKET_W-1:0] heads_waddr, heads_raddr;
    logic [LINK_W-1:0]   heads_wdata, heads_rdata;
    logic                ent_we;
    logic [ENTRY_W-1:0]  ent_waddr, ent_raddr;
    logic [ENT_W-1:0]    ent_wdata, ent_rdata;
    logic                fs_we;
    logic [ENTRY_W-1:0]  fs_waddr, fs_raddr;
    logic [ENTRY_W-1:0]  fs_wdata, fs_rdata;

    logic [KEY_W-1:0]    rd_key;
    logic [VAL_W-1:0]    rd_val;
    logic [LINK_W-1:0]   rd_link;
    logic [HELD_W-1:0]   top_m1;
    logic [ENTRY_W-1:0]  alloc;
    logic                finish;
    logic [STATUS_W-1:0] fin_status;
    logic [VAL_W-1:0]    fin_found;

    function automatic logic is_entry(input logic [LINK_W-1:0] link);
        return link < NIL_LINK;
    endfunction

    cht_ram #(.WIDTH(LINK_W), .DEPTH(MAX_BUCKETS)) u_heads (
        .clk   (clk),
        .we    (heads_we),
        .waddr (heads_waddr),
        .wdata (heads_wdata),
        .raddr (heads_raddr),
        .rdata (heads_rdata)
    );

    cht_ram #(.WIDTH(ENT_W), .DEPTH(POOL_ENTRIES)) u_entries (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    cht_ram #(.WIDTH(ENTRY_W), .DEPTH(POOL_ENTRIES)) u_free (
        .clk   (clk),
        .we    (fs_we),
        .waddr (fs_waddr),
        .wdata (fs_wdata),
        .raddr (fs_raddr),
        .rdata (fs_rdata)
    );

    assign rd_key  = ent_rdata[ENT_W-1 -: KEY_W];
    assign rd_val  = ent_rdata[LINK_W +: VAL_W];
    assign rd_link = ent_rdata[LINK_W-1:0];
    assign top_m1  = top_reg - HELD_W'(1);

    // Free-stack slots below the low-water mark have not been written since the
    // last clear, so their own index is used in place of their contents.
    assign alloc = (top_m1 < low_reg) ? top_m1[ENTRY_W-1:0] : fs_rdata;

    assign init_done          = (state_reg != S_INIT);
    assign pop_ready          = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = status_reg;
    assign out_ch.found_value = found_reg;
    assign out_ch.entry_count = count_reg;

    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        top_next       = top_reg;
        low_next       = low_reg;
        held_next      = held_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        bucket_next    = bucket_reg;
        new_next       = new_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        prev_word_next = prev_word_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        count_next     = count_reg;

        heads_we    = 1'b0;
        heads_waddr = bucket_reg;
        heads_wdata = NIL_LINK;
        heads_raddr = pop_bucket;
        ent_we      = 1'b0;
        ent_waddr   = cur_reg[ENTRY_W-1:0];
        ent_wdata   = {op_reg.key, op_reg.value, NIL_LINK};
        ent_raddr   = rd_link[ENTRY_W-1:0];
        fs_we       = 1'b0;
        fs_waddr    = top_reg[ENTRY_W-1:0];
        fs_wdata    = cur_reg[ENTRY_W-1:0];
        fs_raddr    = top_m1[ENTRY_W-1:0];

        finish     = 1'b0;
        fin_status = STATUS_DONE;
        fin_found  = '0;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT, S_CLEAR:
            begin
                heads_we    = 1'b1;
                heads_waddr = sweep_reg;
                sweep_next  = sweep_reg + BUCKET_W'(1);
                if (sweep_reg == LAST_BUCKET)
                begin
                    state_next = S_IDLE;
                    finish     = (state_reg == S_CLEAR);
                end
            end
            S_IDLE:
            begin
                if (pop_valid && pop_ready)
                begin
                    op_next     = pop_op;
                    bucket_next = pop_bucket;
                    prev_next   = NIL_LINK;
                    if (pop_op.mode == MODE_CLEAR)
                    begin
                        top_next   = POOL_COUNT;
                        low_next   = POOL_COUNT;
                        held_next  = '0;
                        sweep_next = '0;
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_HEAD;
                    end
                end
            end
            S_HEAD:
            begin
                cur_next  = heads_rdata;
                ent_raddr = heads_rdata[ENTRY_W-1:0];
                if (op_reg.mode == MODE_INSERT)
                begin
                    if (top_reg == '0)
                    begin
                        finish     = 1'b1;
                        fin_status = STATUS_FULL;
                    end
                    else
                    begin
                        new_next  = alloc;
                        top_next  = top_m1;
                        held_next = held_reg + HELD_W'(1);
                        if (top_m1 < low_reg)
                        begin
                            low_next = top_m1;
                        end
                        ent_we    = 1'b1;
                        ent_waddr = alloc;
                        ent_wdata = {op_reg.key, op_reg.value, NIL_LINK};
                        if (!is_entry(heads_rdata))
                        begin
                            heads_we    = 1'b1;
                            heads_wdata = LINK_W'(alloc);
                            finish      = 1'b1;
                        end
                        else
                        begin
                            state_next = S_WALK;
                        end
                    end
                end
                else if (!is_entry(heads_rdata))
                begin
                    finish     = 1'b1;
                    fin_status = STATUS_MISSING;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                cur_next = rd_link;
                if (op_reg.mode == MODE_INSERT)
                begin
                    if (!is_entry(rd_link))
                    begin
                        ent_we    = 1'b1;
                        ent_wdata = {rd_key, rd_val, LINK_W'(new_reg)};
                        finish    = 1'b1;
                    end
                end
                else if (rd_key == op_reg.key)
                begin
                    finish = 1'b1;
                    if (op_reg.mode == MODE_GET)
                    begin
                        fin_found = rd_val;
                    end
                    else
                    begin
                        if (is_entry(prev_reg))
                        begin
                            ent_we    = 1'b1;
                            ent_waddr = prev_reg[ENTRY_W-1:0];
                            ent_wdata = {prev_word_reg, rd_link};
                        end
                        else
                        begin
                            heads_we    = 1'b1;
                            heads_wdata = rd_link;
                        end
                        if (top_reg < POOL_COUNT)
                        begin
                            fs_we    = 1'b1;
                            top_next = top_reg + HELD_W'(1);
                        end
                        if (held_reg != '0)
                        begin
                            held_next = held_reg - HELD_W'(1);
                        end
                    end
                end
                else
                begin
                    prev_next      = cur_reg;
                    prev_word_next = {rd_key, rd_val};
                    if (!is_entry(rd_link))
                    begin
                        finish     = 1'b1;
                        fin_status = STATUS_MISSING;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            state_next     = S_IDLE;
            out_valid_next = 1'b1;
            status_next    = fin_status;
            found_next     = fin_found;
            count_next     = COUNT_W'(held_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            sweep_reg     <= '0;
            top_reg       <= POOL_COUNT;
            low_reg       <= POOL_COUNT;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            top_reg       <= top_next;
            low_reg       <= low_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        bucket_reg    <= bucket_next;
        new_reg       <= new_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        prev_word_reg <= prev_word_next;
        status_reg    <= status_next;
        found_reg     <= found_next;
        count_reg     <= count_next;
    end

endmodule

@@ src/chained_hash_table_core.sv @@
// Top level of the separately chained hash table over a fixed entry pool.
//
//   channel   direction  handshake          payload
//   cfg       in         cfg_we             cfg_wdata (bucket_count)
//   in_ch     in         valid/ready        mode, lookup_key, entry_value
//   out_ch    out        valid/ready        status, found_value, entry_count
//
// The front end folds four key bits per cycle into the bucket remainder, then hands
// the item over to the queue; only after that does it accept the next item.
// The back end reads the bucket head, then visits chain entries through the entry RAM
// read port; a clear sweeps all MAX_BUCKETS heads.
// After reset, in_ch.ready stays low while the heads are cleared. A stalled result
// holds the back end; the front end runs on until the two-entry queue fills.
module chained_hash_table_core #(
    parameter int MAX_BUCKETS  = 64,
    parameter int POOL_ENTRIES = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [cht_pkg::CFG_W-1:0] cfg_wdata,
    cht_in_if.sink                    in_ch,
    cht_out_if.source                 out_ch
);
    import cht_pkg::*;

    localparam int BUCKET_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int QUEUE_W  = $bits(cht_op_t) + BUCKET_W;

    logic [CFG_W-1:0]    bucket_count_reg;
    logic                init_done;
    logic                push_valid, push_ready;
    cht_op_t             push_op;
    logic [BUCKET_W-1:0] push_bucket;
    logic                pop_valid, pop_ready;
    logic [QUEUE_W-1:0]  pop_data;
    cht_op_t             pop_op;
    logic [BUCKET_W-1:0] pop_bucket;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= BUCKET_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            bucket_count_reg <= cfg_wdata;
        end
    end

    cht_front #(.MAX_BUCKETS(MAX_BUCKETS), .BUCKET_W(BUCKET_W)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .bucket_count (bucket_count_reg),
        .init_done    (init_done),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_op      (push_op),
        .push_bucket  (push_bucket)
    );

    cht_queue #(.WIDTH(QUEUE_W)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_op, push_bucket}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign pop_op     = pop_data[QUEUE_W-1:BUCKET_W];
    assign pop_bucket = pop_data[BUCKET_W-1:0];

    cht_back #(
        .MAX_BUCKETS  (MAX_BUCKETS),
        .POOL_ENTRIES (POOL_ENTRIES),
        .BUCKET_W     (BUCKET_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op),
        .pop_bucket (pop_bucket),
        .init_done  (init_done),
        .out_ch     (out_ch)
    );

endmodule

@@ src/cht_checker.sv @@
// Port-level assertions for the hash table and the bind that attaches them.
module cht_checker #(
    parameter int POOL_ENTRIES = 256
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [cht_pkg::STATUS_W-1:0] status,
    input logic [cht_pkg::VAL_W-1:0]    found_value,
    input logic [cht_pkg::COUNT_W-1:0]  entry_count
);
    import cht_pkg::*;

    // A result that is not taken stays offered with its status and count unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_count))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_DONE) || (status == STATUS_MISSING)
                      || (status == STATUS_FULL))
        else $error("undefined status code");

    // A result that is not done carries a zero value.
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STATUS_DONE) |-> (found_value == '0))
        else $error("value reported without a hit");

    // The pool is full only when every entry is held.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_FULL) |-> (entry_count == COUNT_W'(POOL_ENTRIES)))
        else $error("pool full reported with free entries");

    a_reset_ready: assert property (@(posedge clk) !rst_n |-> !in_ready)
        else $error("items accepted during reset");

endmodule

bind chained_hash_table_core cht_checker #(.POOL_ENTRIES(POOL_ENTRIES)) u_cht_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .status      (out_ch.status),
    .found_value (out_ch.found_value),
    .entry_count (out_ch.entry_count)
);

@@ dv/chained_hash_table_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the chained hash table core with a scoreboard class.
module testbench;
    import cht_pkg::*;

    localparam int NBUCKETS = 64;
    localparam int NPOOL    = 256;
    localparam int NIL      = NPOOL;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [VAL_W-1:0] value;
        logic [COUNT_W-1:0]      count;
    } table_result_t;

    class table_scoreboard;
        int unsigned heads[NBUCKETS];
        logic [KEY_W-1:0] keys[NPOOL];
        logic [VAL_W-1:0] vals[NPOOL];
        int unsigned links[NPOOL];
        int unsigned free_list[NPOOL];
        int unsigned free_top;
        int unsigned held;
        logic [CFG_W-1:0] buckets;
        table_result_t pending[$];
        int mismatches;
        int checked;

        function void empty_table();
            for (int i = 0; i < NBUCKETS; i++)
                heads[i] = NIL;
            for (int i = 0; i < NPOOL; i++)
                free_list[i] = i;
            free_top = NPOOL;
            held = 0;
        endfunction

        function void reset_state();
            buckets = BUCKET_COUNT_RESET;
            mismatches = 0;
            checked = 0;
            for (int i = 0; i < NPOOL; i++)
                links[i] = NIL;
            empty_table();
        endfunction

        function int unsigned bucket_of(logic [KEY_W-1:0] key);
            int unsigned bc;
            bc = buckets;
            if (bc == 0)
                bc = 1;
            if (bc > NBUCKETS)
                bc = NBUCKETS;
            return (key % bc) % NBUCKETS;
        endfunction

        // Works out the result of one accepted operation and queues it.
        function void note_op(cht_op_t op);
            table_result_t r;
            int unsigned b, cur, prev, e;
            r = '0;
            b = bucket_of(op.key);
            case (op.mode)
                MODE_INSERT:
                begin
                    if (free_top == 0)
                        r.status = STATUS_FULL;
                    else
                    begin
                        e = free_list[free_top - 1];
                        free_top--;
                        keys[e] = op.key;
                        vals[e] = op.value;
                        links[e] = NIL;
                        cur = heads[b];
                        if (cur == NIL)
                            heads[b] = e;
                        else
                        begin
                            while (links[cur] != NIL)
                                cur = links[cur];
                            links[cur] = e;
                        end
                        held++;
                    end
                end
                MODE_GET:
                begin
                    r.status = STATUS_MISSING;
                    cur = heads[b];
                    while (cur != NIL)
                    begin
                        if (keys[cur] == op.key)
                        begin
                            r.status = STATUS_DONE;
                            r.value = vals[cur];
                            break;
                        end
                        cur = links[cur];
                    end
                end
                MODE_REMOVE:
                begin
                    r.status = STATUS_MISSING;
                    prev = NIL;
                    cur = heads[b];
                    while (cur != NIL)
                    begin
                        if (keys[cur] == op.key)
                        begin
                            if (prev != NIL)
                                links[prev] = links[cur];
                            else
                                heads[b] = links[cur];
                            links[cur] = NIL;
                            free_list[free_top++] = cur;
                            held--;
                            r.status = STATUS_DONE;
                            break;
                        end
                        prev = cur;
                        cur = links[cur];
                    end
                end
                default:
                    empty_table();
            endcase
            r.count = COUNT_W'(held);
            pending.push_back(r);
        endfunction

        function void check_result(table_result_t got);
            table_result_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d value %0d count %0d",
                             got.status, got.value, got.count);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: expected status %0d value %0d count %0d, %s %0d %0d %0d",
                             checked, want.status, want.value, want.count, "got",
                             got.status, got.value, got.count);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    cht_in_if  in_ch ();
    cht_out_if out_ch ();

    chained_hash_table_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    table_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int unsigned cycles;
    int unsigned sent;
    logic [KEY_W-1:0] recent_keys[$];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // Result side: sample at the rising edge, move ready at the falling edge.
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
                sb.check_result({out_ch.status, out_ch.found_value, out_ch.entry_count});
            @(negedge clk);
            out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Valid is left high on return; an idle cycle or a drain lowers it, or the next item takes its place.
    task automatic send_op(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                           logic [VAL_W-1:0] value);
        cht_op_t op;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        op.mode = mode;
        op.key = key;
        op.value = value;
        in_ch.valid <= 1'b1;
        in_ch.mode <= mode;
        in_ch.lookup_key <= key;
        in_ch.entry_value <= value;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_op(op);
        sent++;
        if (mode == MODE_INSERT)
        begin
            recent_keys.push_back(key);
            if (recent_keys.size() > 40)
                void'(recent_keys.pop_front());
        end
        @(negedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        // Allow a full chain walk or a clear sweep to settle.
        repeat (NPOOL + NBUCKETS + 20) @(negedge clk);
    endtask

    task automatic write_buckets(logic [CFG_W-1:0] value);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.buckets = value;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 6 && recent_keys.size() != 0)
            return recent_keys[$urandom_range(recent_keys.size() - 1)];
        if (sel < 8)
            return KEY_W'($urandom_range(300));
        return KEY_W'($urandom);
    endfunction

    task automatic random_ops(int n);
        int unsigned m;
        for (int i = 0; i < n; i++)
        begin
            m = $urandom_range(99);
            if (m < 45)
                send_op(MODE_INSERT, pick_key(), $urandom);
            else if (m < 70)
                send_op(MODE_GET, pick_key(), $urandom);
            else if (m < 98)
                send_op(MODE_REMOVE, pick_key(), $urandom);
            else
                send_op(MODE_CLEAR, KEY_W'($urandom), $urandom);
        end
    endtask

    initial
    begin
        sb = new();
        sb.reset_state();
        sent = 0;
        send_idle_pct = 7;
        recv_idle_pct = 69;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.mode = MODE_INSERT;
        in_ch.lookup_key = '0;
        in_ch.entry_value = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, duplicates, head removal, missing keys, clear.
        send_op(MODE_INSERT, 31'h7fffffff, 32'h7fffffff);
        send_op(MODE_INSERT, '0, 32'h80000000);
        send_op(MODE_INSERT, 31'd64, 32'hffffffff);
        send_op(MODE_INSERT, 31'd64, 32'd5);
        send_op(MODE_GET, 31'd64, '0);
        send_op(MODE_GET, 31'h7fffffff, '1);
        send_op(MODE_GET, 31'd128, '0);
        send_op(MODE_REMOVE, '0, '0);
        send_op(MODE_REMOVE, 31'd64, '0);
        send_op(MODE_GET, 31'd64, '0);
        send_op(MODE_REMOVE, 31'd999, '0);
        send_op(MODE_CLEAR, '1, '1);
        send_op(MODE_GET, 31'd64, '0);
        send_op(MODE_INSERT, 31'd3, 32'd3);

        // Bucket count changed while holding entries, then zero and oversize.
        write_buckets(7'd5);
        send_op(MODE_GET, 31'd3, '0);
        send_op(MODE_INSERT, 31'd3, 32'd33);
        send_op(MODE_GET, 31'd3, '0);
        write_buckets(7'd0);
        send_op(MODE_INSERT, 31'd17, 32'd1);
        send_op(MODE_GET, 31'd17, '0);
        write_buckets(7'd127);
        send_op(MODE_GET, 31'd17, '0);

        // Fill the pool past its end, with one chain that is long.
        write_buckets(7'd1);
        send_op(MODE_CLEAR, '0, '0);
        for (int i = 0; i < NPOOL + 2; i++)
            send_op(MODE_INSERT, KEY_W'(i), VAL_W'(i));
        send_op(MODE_REMOVE, 31'd255, '0);
        send_op(MODE_CLEAR, '0, '0);

        write_buckets(7'd64);
        random_ops(80);
        send_idle_pct = 69;
        recv_idle_pct = 7;
        write_buckets(7'd7);
        random_ops(80);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_buckets(7'd1);
        random_ops(50);
        write_buckets(7'd33);
        random_ops(59);

        drain();
        $display("%0d operations sent, %0d results checked", sent, sb.checked);
        $display("bucket counts from 0 to 127 were used and the pool was filled past its end");
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("testbench OK");
        else
        begin
            $display("%0d mismatches", sb.mismatches);
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule
